/* rtl/tppm_pkg.sv */
// tppm_pkg: shared types and constants for the three-phase power metrics block
// no dependencies

package tppm_pkg;

   // config register indexes
   localparam int unsigned REG_MIN_VALID_VOLTAGE = 0;
   localparam int unsigned REG_MIN_APPARENT_VA   = 1;

   localparam logic [23:0] APPARENT_MAX = 24'hFFFFFF;
   localparam logic [15:0] PF_ONE       = 16'd32768;

   // radicand width: 2*(2^20)^2 < 2^42
   localparam int unsigned RAD_W   = 42;
   localparam int unsigned ROOT_W  = 21;
   // dividend |P|*32768 < 2^36, divisor 24 bits, quotient kept to 17 bits
   localparam int unsigned DVD_W   = 36;
   localparam int unsigned QUO_W   = 17;

   // payload carried down the cell chain
   typedef struct packed {
      logic [17:0]        total_current;
      logic [15:0]        mean_voltage;
      logic [15:0]        current_imbalance;
      logic signed [20:0] net_power;
      logic [19:0]        abs_p;
      logic [34:0]        vi_sum;      // sum of V*I, 0.001 VA
      logic [15:0]        min_va;
   } carry_type;

   // square root working state
   typedef struct packed {
      logic [RAD_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   // divider working state
   typedef struct packed {
      logic [DVD_W-1:0] dvd;      // shifting dividend
      logic [24:0]      rem;      // partial remainder
      logic [QUO_W-1:0] quo;
      logic [23:0]      dvs;
   } div_type;

endpackage

/* rtl/tppm_sqrt_cell.sv */
// tppm_sqrt_cell: one digit of the restoring square root, registered
// depends on tppm_pkg

module tppm_sqrt_cell #(
   parameter int unsigned STEP = 0
) (
   input  logic                  clock,
   input  logic                  advance,
   input  tppm_pkg::sqrt_type    sq_in,
   input  tppm_pkg::carry_type   cy_in,
   output tppm_pkg::sqrt_type    sq_out,
   output tppm_pkg::carry_type   cy_out
);
   localparam int unsigned SH = 2 * (tppm_pkg::ROOT_W - 1 - STEP);

   tppm_pkg::sqrt_type  sq_ff, sq_in_nx;
   tppm_pkg::carry_type cy_ff;
   logic [tppm_pkg::RAD_W+1:0] trial;
   logic [tppm_pkg::RAD_W+1:0] part;

   // try root digit one: compare remainder against (4*root+1) << sh
   always_comb begin
      part  = {{(tppm_pkg::RAD_W+2-tppm_pkg::ROOT_W-2){1'b0}}, sq_in.root, 2'b01} << SH;
      trial = {2'b00, sq_in.rem};
      sq_in_nx = sq_in;
      sq_in_nx.root = {sq_in.root[tppm_pkg::ROOT_W-2:0], 1'b0};
      if (trial >= part) begin
         sq_in_nx.rem  = tppm_pkg::RAD_W'(trial - part);
         sq_in_nx.root = {sq_in.root[tppm_pkg::ROOT_W-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff <= sq_in_nx;
         cy_ff <= cy_in;
      end
   end

   assign sq_out = sq_ff;
   assign cy_out = cy_ff;
endmodule

/* rtl/tppm_div_cell.sv */
// tppm_div_cell: one quotient bit of the restoring divider, registered
// depends on tppm_pkg

module tppm_div_cell (
   input  logic                  clock,
   input  logic                  advance,
   input  tppm_pkg::div_type     dv_in,
   input  tppm_pkg::carry_type   cy_in,
   output tppm_pkg::div_type     dv_out,
   output tppm_pkg::carry_type   cy_out
);
   tppm_pkg::div_type   dv_ff, dv_nx;
   tppm_pkg::carry_type cy_ff;
   logic [25:0] shifted;

   // shift in next dividend bit, subtract divisor when it fits
   always_comb begin
      shifted = {dv_in.rem, dv_in.dvd[tppm_pkg::DVD_W-1]};
      dv_nx = dv_in;
      dv_nx.dvd = {dv_in.dvd[tppm_pkg::DVD_W-2:0], 1'b0};
      dv_nx.quo = {dv_in.quo[tppm_pkg::QUO_W-2:0], 1'b0};
      if (shifted >= {2'b00, dv_in.dvs}) begin
         dv_nx.rem = 25'(shifted - {2'b00, dv_in.dvs});
         dv_nx.quo = {dv_in.quo[tppm_pkg::QUO_W-2:0], 1'b1};
      end else begin
         dv_nx.rem = shifted[24:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_ff <= dv_nx;
         cy_ff <= cy_in;
      end
   end

   assign dv_out = dv_ff;
   assign cy_out = cy_ff;
endmodule

/* rtl/three_phase_power_metrics.sv */
// three_phase_power_metrics: top level, front stages, cell chains and output
// depends on tppm_pkg, tppm_sqrt_cell, tppm_div_cell

// One snapshot is accepted per clock while the pipeline advances; each result passes through the stages
// (front end 3, square-root chain 21, select 1, divider chain 36, finish 3, output 1);
// the depth is set by the two bit-per-cell chains for the square root and
// the power-factor division. The whole pipeline advances only when the output
// register is empty or being taken, so back-pressure stalls every stage.

module three_phase_power_metrics (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [19:0]        req_active_import,
   input  logic [19:0]        req_active_export,
   input  logic [19:0]        req_reactive_import,
   input  logic [19:0]        req_reactive_export,
   input  logic [15:0]        req_current_one,
   input  logic [15:0]        req_current_two,
   input  logic [15:0]        req_current_three,
   input  logic [15:0]        req_voltage_one,
   input  logic [15:0]        req_voltage_two,
   input  logic [15:0]        req_voltage_three,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [17:0]        rsp_total_current,
   output logic [15:0]        rsp_mean_voltage,
   output logic [15:0]        rsp_current_imbalance,
   output logic signed [20:0] rsp_net_power,
   output logic [23:0]        rsp_apparent_power,
   output logic [15:0]        rsp_power_factor,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   localparam int unsigned NSQ  = tppm_pkg::ROOT_W;
   localparam int unsigned NDV  = tppm_pkg::DVD_W;
   localparam int unsigned NPIPE = 3 + NSQ + 1 + NDV + 3;

   logic [15:0] min_volt_ff, min_va_ff;
   logic        advance;
   logic [NPIPE-1:0] vld_ff;
   logic        out_vld_ff;

   // config registers
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_volt_ff <= 16'd10;
         min_va_ff   <= 16'd1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            1'(tppm_pkg::REG_MIN_VALID_VOLTAGE):
               if (csr_paddr[1:0] == 2'b00) min_volt_ff <= csr_pwdata[15:0];
            1'(tppm_pkg::REG_MIN_APPARENT_VA):
               if (csr_paddr[1:0] == 2'b00) min_va_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (csr_paddr[2])
         1'(tppm_pkg::REG_MIN_VALID_VOLTAGE): csr_prdata = {16'd0, min_volt_ff};
         1'(tppm_pkg::REG_MIN_APPARENT_VA):   csr_prdata = {16'd0, min_va_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   // stall whole pipe when the output register is full and not taken
   assign advance   = !out_vld_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff     <= {vld_ff[NPIPE-2:0], req_valid};
         out_vld_ff <= vld_ff[NPIPE-1];
      end
   end
   assign rsp_valid = out_vld_ff;

   // front stage one: present flags, sums, differences
   logic [15:0] c1_ff[3], v1_ff[3];
   logic [2:0]  pres1_ff;
   logic [17:0] tot1_ff;
   logic signed [20:0] net1_ff, q1_ff;
   logic [15:0] minva1_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         c1_ff[0] <= req_current_one;
         c1_ff[1] <= req_current_two;
         c1_ff[2] <= req_current_three;
         v1_ff[0] <= req_voltage_one;
         v1_ff[1] <= req_voltage_two;
         v1_ff[2] <= req_voltage_three;
         pres1_ff <= {req_voltage_three > min_volt_ff, req_voltage_two > min_volt_ff,
                      req_voltage_one > min_volt_ff};
         tot1_ff  <= 18'(req_current_one) + 18'(req_current_two) + 18'(req_current_three);
         net1_ff  <= $signed({1'b0, req_active_import}) - $signed({1'b0, req_active_export});
         q1_ff    <= $signed({1'b0, req_reactive_import}) - $signed({1'b0, req_reactive_export});
         minva1_ff <= min_va_ff;
      end
   end

   // front stage two: products, max/min, abs values
   logic [31:0] vi2_ff[3];
   logic [15:0] v2_ff[3];
   logic [2:0]  pres2_ff;
   logic [17:0] tot2_ff;
   logic [15:0] imb2_ff;
   logic signed [20:0] net2_ff;
   logic [19:0] ap2_ff, aq2_ff;
   logic [15:0] minva2_ff;
   logic [15:0] cmax, cmin;
   always_comb begin
      cmax = c1_ff[0];
      cmin = c1_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (c1_ff[i] > cmax) cmax = c1_ff[i];
         if (c1_ff[i] < cmin) cmin = c1_ff[i];
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            vi2_ff[i] <= pres1_ff[i] ? v1_ff[i] * c1_ff[i] : 32'd0;
            v2_ff[i]  <= pres1_ff[i] ? v1_ff[i] : 16'd0;
         end
         pres2_ff  <= pres1_ff;
         tot2_ff   <= tot1_ff;
         imb2_ff   <= cmax - cmin;
         net2_ff   <= net1_ff;
         ap2_ff    <= net1_ff[20] ? 20'(-net1_ff) : net1_ff[19:0];
         aq2_ff    <= q1_ff[20] ? 20'(-q1_ff) : q1_ff[19:0];
         minva2_ff <= minva1_ff;
      end
   end

   // front stage three: squares and V*I sum, mean voltage
   logic [39:0] pp3_ff, qq3_ff;
   tppm_pkg::carry_type cy3_ff;
   logic [17:0] vs;
   logic [1:0]  vc;
   logic [15:0] mean;
   always_comb begin
      vs = 18'(v2_ff[0]) + 18'(v2_ff[1]) + 18'(v2_ff[2]);
      vc = 2'(pres2_ff[0]) + 2'(pres2_ff[1]) + 2'(pres2_ff[2]);
      // divide by 1, 2 or 3; by 3 via reciprocal multiply (exact for 18 bits)
      case (vc)
         2'd1: mean = vs[15:0];
         2'd2: mean = vs[16:1];
         2'd3: mean = 16'((37'(vs) * 37'd174763) >> 19);
         default: mean = 16'd0;
      endcase
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         pp3_ff <= ap2_ff * ap2_ff;
         qq3_ff <= aq2_ff * aq2_ff;
         cy3_ff.total_current     <= tot2_ff;
         cy3_ff.mean_voltage      <= mean;
         cy3_ff.current_imbalance <= imb2_ff;
         cy3_ff.net_power         <= net2_ff;
         cy3_ff.abs_p             <= ap2_ff;
         cy3_ff.vi_sum            <= 35'(vi2_ff[0]) + 35'(vi2_ff[1]) + 35'(vi2_ff[2]);
         cy3_ff.min_va            <= minva2_ff;
      end
   end

   // square-root chain
   tppm_pkg::sqrt_type  sq[NSQ+1];
   tppm_pkg::carry_type sqc[NSQ+1];
   assign sq[0].rem  = tppm_pkg::RAD_W'(pp3_ff) + tppm_pkg::RAD_W'(qq3_ff);
   assign sq[0].root = '0;
   assign sqc[0]     = cy3_ff;
   for (genvar g = 0; g < NSQ; g++) begin : g_sq
      tppm_sqrt_cell #(.STEP(g)) u_cell (
         .clock(clock), .advance(advance),
         .sq_in(sq[g]), .cy_in(sqc[g]), .sq_out(sq[g+1]), .cy_out(sqc[g+1])
      );
   end

   // select apparent power: root or V*I fallback (divide by 1000 via reciprocal)
   logic [31:0] vi_y;
   logic [24:0] vi_k;
   logic [24:0] fb;
   logic [23:0] app_sel;
   logic [63:0] recip;
   always_comb begin
      // floor(x/1000) = floor((x>>3)/125); (x>>3) < 2^31, times ceil(2^38/125)
      vi_y  = sqc[NSQ].vi_sum[34:3];
      recip = 64'(vi_y) * 64'd2199023256;
      vi_k  = 25'(recip >> 38);
      fb = (vi_k > 25'(tppm_pkg::APPARENT_MAX)) ? 25'(tppm_pkg::APPARENT_MAX) : vi_k;
      if (23'(sq[NSQ].root) > 23'(sqc[NSQ].min_va) || sq[NSQ].root > 21'(sqc[NSQ].min_va))
         app_sel = 24'(sq[NSQ].root);
      else
         app_sel = fb[23:0];
   end

   logic [23:0] app_s_ff;
   tppm_pkg::carry_type cys_ff;
   tppm_pkg::div_type dv[NDV+1];
   tppm_pkg::carry_type dvc[NDV+1];
   logic [23:0] app_d[NDV+1];
   always_ff @(posedge clock) begin
      if (advance) begin
         app_s_ff <= app_sel;
         cys_ff   <= sqc[NSQ];
      end
   end
   assign dv[0].dvd = {1'b0, cys_ff.abs_p, 15'd0};
   assign dv[0].rem = '0;
   assign dv[0].quo = '0;
   assign dv[0].dvs = (app_s_ff == 24'd0) ? 24'd1 : app_s_ff;
   assign dvc[0]    = cys_ff;
   assign app_d[0]  = app_s_ff;

   // divider chain
   for (genvar g = 0; g < NDV; g++) begin : g_dv
      logic [23:0] app_ff;
      tppm_div_cell u_cell (
         .clock(clock), .advance(advance),
         .dv_in(dv[g]), .cy_in(dvc[g]), .dv_out(dv[g+1]), .cy_out(dvc[g+1])
      );
      always_ff @(posedge clock) begin
         if (advance) app_ff <= app_d[g];
      end
      assign app_d[g+1] = app_ff;
   end

   // finish: cap, threshold, then three retiming stages
   logic [15:0] pf_f;
   logic [23:0] app_f;
   always_comb begin
      app_f = app_d[NDV];
      if (app_f > 24'(dvc[NDV].min_va))
         pf_f = (dv[NDV].quo > 17'(tppm_pkg::PF_ONE)) ? tppm_pkg::PF_ONE : dv[NDV].quo[15:0];
      else
         pf_f = 16'd0;
   end

   logic [15:0] pf_r[3];
   logic [23:0] app_r[3];
   tppm_pkg::carry_type cy_r[3];
   always_ff @(posedge clock) begin
      if (advance) begin
         pf_r[0] <= pf_f;  app_r[0] <= app_f;  cy_r[0] <= dvc[NDV];
         for (int i = 1; i < 3; i++) begin
            pf_r[i] <= pf_r[i-1]; app_r[i] <= app_r[i-1]; cy_r[i] <= cy_r[i-1];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_total_current     <= cy_r[2].total_current;
         rsp_mean_voltage      <= cy_r[2].mean_voltage;
         rsp_current_imbalance <= cy_r[2].current_imbalance;
         rsp_net_power         <= cy_r[2].net_power;
         rsp_apparent_power    <= app_r[2];
         rsp_power_factor      <= pf_r[2];
      end
   end
endmodule
